// ===== design/fly_camera_frame_update_unit_macros.svh =====
// Assertion macros for the fly camera frame update unit.
// Used by the controller and the top level; no dependencies.
`ifndef FLY_CAMERA_FRAME_UPDATE_UNIT_MACROS_SVH
`define FLY_CAMERA_FRAME_UPDATE_UNIT_MACROS_SVH
`define FCFU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define FCFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/fcfu_pkg.sv =====
// Types, constants and the sine table for the fly camera frame update unit.
// No dependencies.
package fcfu_pkg;
  localparam int RollHalf = 46080;
  localparam int RollFull = 92160;

  localparam logic RegMoveSpeed = 1'b0;
  localparam logic RegTurnSpeed = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_ANGLE, ST_TRIG, ST_VEC, ST_VEL,
    ST_MOVE, ST_MOVE_ADD, ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scale;
    logic angle;
    logic trig;
    logic vec;
    logic vel;
    logic move_mul;
    logic move_add;
    logic [1:0] key_idx;
    logic [1:0] comp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic key_active;
  } stat_t;

  function automatic logic [14:0] sine_lut(input logic [6:0] a);
    logic [14:0] t [0:90];
    t = '{15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
          15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
          15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
          15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
          15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
          15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
          15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
          15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
          15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
          15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
          15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
          15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
          15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
          15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
          15'd16384};
    if (a > 7'd90) begin
      sine_lut = 15'd0;
    end else begin
      sine_lut = t[a];
    end
  endfunction

  // a in 0..359
  function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
    logic [8:0] i;
    logic neg;
    i = 9'd0;
    neg = 1'b0;
    if (a <= 9'd90) begin
      i = a;
    end else if (a <= 9'd180) begin
      i = 9'd180 - a;
    end else if (a <= 9'd270) begin
      i = a - 9'd180;
      neg = 1'b1;
    end else begin
      i = 9'd360 - a;
      neg = 1'b1;
    end
    sin_deg = neg ? -$signed({1'b0, sine_lut(i[6:0])})
                  : $signed({1'b0, sine_lut(i[6:0])});
  endfunction

  function automatic logic signed [15:0] cos_deg(input logic [8:0] a);
    logic [9:0] s;
    s = {1'b0, a} + 10'd90;
    if (s >= 10'd360) begin
      s = s - 10'd360;
    end
    cos_deg = sin_deg(s[8:0]);
  endfunction

  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic [31:0] m;
    logic [31:0] r;
    p = a * b;
    m = p[31] ? 32'(-p) : 32'(p);
    r = (m + 32'd8192) >> 14;
    mul_q14 = p[31] ? -$signed(r[15:0]) : $signed(r[15:0]);
  endfunction
endpackage

// ===== design/fly_camera_frame_update_unit.sv =====
// Top level of the fly camera frame update unit.
// Depends on fcfu_pkg, fcfu_ctrl, fcfu_dp and the macros header.
// A frame runs five fixed steps after the load (scale, angle update, trig lookup,
// vector build, velocity), then, for each of the four move keys, a skip if released
// or a multiply and an add per position component if held, as the single shared
// 16x32 multiplier serves the three position components in turn, then a step that
// registers the result, waiting while an earlier result is stalled. A frame is taken
// only when the previous one is finished, at the earliest the cycle after its result is
// registered; the result register lets the next frame start while a result still waits.
`include "fly_camera_frame_update_unit_macros.svh"
module fly_camera_frame_update_unit #(
  parameter int PitchUpper = 89,
  parameter int PitchLower = -89
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] mouse_dx_i,
  input  logic signed [15:0] mouse_dy_i,
  input  logic [15:0]        frame_time_i,
  input  logic               key_forward_i,
  input  logic               key_back_i,
  input  logic               key_left_i,
  input  logic               key_right_i,
  input  logic               key_roll_minus_i,
  input  logic               key_roll_plus_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic [8:0]         yaw_deg_o,
  output logic signed [7:0]  pitch_deg_o,
  output logic signed [16:0] roll_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  fcfu_pkg::cmd_t cmd;
  fcfu_pkg::stat_t stat;
  logic signed [31:0] pos [3];
  logic signed [15:0] front [3], up [3];

  assign cfg_ready_o = 1'b1;

  fcfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  fcfu_dp #(
    .PitchUpper(PitchUpper),
    .PitchLower(PitchLower)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .mouse_dx_i, .mouse_dy_i, .frame_time_i,
    .keys_i({key_roll_plus_i, key_roll_minus_i, key_right_i, key_left_i,
             key_back_i, key_forward_i}),
    .pos_o(pos), .front_o(front), .up_o(up),
    .yaw_o(yaw_deg_o), .pitch_o(pitch_deg_o), .roll_o(roll_angle_o)
  );

  assign pos_x_o = pos[0];
  assign pos_y_o = pos[1];
  assign pos_z_o = pos[2];
  assign front_x_o = front[0];
  assign front_y_o = front[1];
  assign front_z_o = front[2];
  assign up_x_o = up[0];
  assign up_y_o = up[1];
  assign up_z_o = up[2];

  `FCFU_ASSERT_IMPL(a_yaw_range, clk_i, rst_ni, out_valid_o, yaw_deg_o < 9'd360,
    "yaw out of range")
  `FCFU_ASSERT_IMPL(a_pitch_range, clk_i, rst_ni, out_valid_o,
    pitch_deg_o <= 8'(PitchUpper) && pitch_deg_o >= 8'(PitchLower), "pitch out of range")
endmodule

// ===== design/fcfu_ctrl.sv =====
// Sequencer for the frame update: steps the datapath through one frame.
// Depends on fcfu_pkg and the macros header.
`include "fly_camera_frame_update_unit_macros.svh"
module fcfu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  fcfu_pkg::stat_t stat_i,
  output fcfu_pkg::cmd_t  cmd_o
);
  fcfu_pkg::state_e state_q, state_d;
  logic [1:0] key_q, key_d;
  logic [1:0] comp_q, comp_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcfu_pkg::ST_IDLE;
      key_q <= 2'd0;
      comp_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      key_q <= key_d;
      comp_q <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    key_d = key_q;
    comp_d = comp_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    cmd_o.key_idx = key_q;
    cmd_o.comp = comp_q;
    in_stall_o = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      fcfu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = fcfu_pkg::ST_SCALE;
        end
      end
      fcfu_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = fcfu_pkg::ST_ANGLE;
      end
      fcfu_pkg::ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d = fcfu_pkg::ST_TRIG;
      end
      fcfu_pkg::ST_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d = fcfu_pkg::ST_VEC;
      end
      fcfu_pkg::ST_VEC: begin
        cmd_o.vec = 1'b1;
        state_d = fcfu_pkg::ST_VEL;
      end
      fcfu_pkg::ST_VEL: begin
        cmd_o.vel = 1'b1;
        key_d = 2'd0;
        comp_d = 2'd0;
        state_d = fcfu_pkg::ST_MOVE;
      end
      fcfu_pkg::ST_MOVE: begin
        if (stat_i.key_active) begin
          cmd_o.move_mul = 1'b1;
          state_d = fcfu_pkg::ST_MOVE_ADD;
        end else if (key_q == 2'd3) begin
          state_d = fcfu_pkg::ST_DONE;
        end else begin
          key_d = key_q + 2'd1;
        end
      end
      fcfu_pkg::ST_MOVE_ADD: begin
        cmd_o.move_add = 1'b1;
        if (comp_q == 2'd2) begin
          comp_d = 2'd0;
          if (key_q == 2'd3) begin
            state_d = fcfu_pkg::ST_DONE;
          end else begin
            key_d = key_q + 2'd1;
            state_d = fcfu_pkg::ST_MOVE;
          end
        end else begin
          comp_d = comp_q + 2'd1;
          state_d = fcfu_pkg::ST_MOVE;
        end
      end
      fcfu_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = fcfu_pkg::ST_IDLE;
        end
      end
      default: state_d = fcfu_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `FCFU_ASSERT_IMPL(a_comp_range, clk_i, rst_ni, 1'b1, comp_q != 2'd3, "comp overflow")
  `FCFU_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, cmd_o.load,
    state_q == fcfu_pkg::ST_SCALE, "load did not start")
  `FCFU_ASSERT_IMPL(a_finish_free, clk_i, rst_ni, cmd_o.finish,
    !out_valid_q || !out_stall_i, "result overwritten")
endmodule

// ===== design/fcfu_dp.sv =====
// Datapath for the frame update: angles, trig lookup, a shared move multiplier, position.
// Depends on fcfu_pkg.
module fcfu_dp #(
  parameter int PitchUpper = 89,
  parameter int PitchLower = -89
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fcfu_pkg::cmd_t         cmd_i,
  output fcfu_pkg::stat_t        stat_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic signed [15:0]     mouse_dx_i,
  input  logic signed [15:0]     mouse_dy_i,
  input  logic [15:0]            frame_time_i,
  input  logic [5:0]             keys_i,
  output logic signed [31:0]     pos_o [3],
  output logic signed [15:0]     front_o [3],
  output logic signed [15:0]     up_o [3],
  output logic [8:0]             yaw_o,
  output logic signed [7:0]      pitch_o,
  output logic signed [16:0]     roll_o
);
  logic [15:0] move_speed_q;
  logic [9:0] turn_speed_q;
  logic signed [31:0] pos_q [3];
  logic signed [15:0] front_q [3], right_q [3], up_q [3];
  logic signed [31:0] pos_out_q [3];
  logic signed [15:0] front_out_q [3], up_out_q [3];
  logic [8:0] yaw_q, yaw_out_q;
  logic signed [7:0] pitch_q, pitch_out_q;
  logic signed [16:0] roll_q, roll_out_q;
  logic signed [15:0] dx_q, dy_q;
  logic [15:0] ft_q;
  logic [5:0] keys_q;
  logic signed [17:0] sx_q, sy_q;
  logic signed [15:0] sy_t_q, cy_t_q, sp_t_q, cp_t_q;
  logic [31:0] vel_q;
  logic signed [47:0] prod_q;

  logic signed [26:0] px, py;
  logic signed [17:0] qx, qy;
  logic signed [19:0] yaw_sum;
  logic [39:0] yaw_prod;
  logic [9:0] yaw_quo;
  logic [18:0] yaw_rem;
  logic signed [18:0] np;
  logic signed [18:0] rsum;
  logic signed [15:0] dir;
  logic [47:0] mag;
  logic signed [33:0] disp;
  logic signed [33:0] dsel;
  logic signed [33:0] psum;
  logic signed [13:0] rstep;
  logic [1:0] k;
  logic [1:0] c;

  assign k = cmd_i.key_idx;
  assign c = cmd_i.comp;
  assign stat_o.key_active = keys_q[k];

  always_comb begin
    px = mouse_dx_prod(dx_q, turn_speed_q);
    py = mouse_dx_prod(dy_q, turn_speed_q);
    qx = 18'(px[26] ? -((-px) >>> 8) : (px >>> 8));
    qy = 18'(py[26] ? -((-py) >>> 8) : (py >>> 8));
  end

  function automatic logic signed [26:0] mouse_dx_prod(input logic signed [15:0] d,
                                                      input logic [9:0] t);
    mouse_dx_prod = 27'(d * $signed({1'b0, t}));
  endfunction

  // bias yaw + sx into 96..262339, then reduce modulo 360 by reciprocal multiply
  always_comb begin
    yaw_sum = 20'($signed({11'd0, yaw_q})) + 20'(sx_q) + 20'sd131040;
    yaw_prod = 40'(yaw_sum[18:0]) * 40'd745655;
    yaw_quo = yaw_prod[37:28];
    yaw_rem = yaw_sum[18:0] - 19'(yaw_quo * 10'd360);
    np = 19'(pitch_q) - 19'(sy_q);
    if (np >= 19'(PitchUpper)) begin
      np = 19'(PitchUpper);
    end
    if (np <= 19'(PitchLower)) begin
      np = 19'(PitchLower);
    end
  end

  always_comb begin
    case (k)
      2'd0, 2'd1: dir = front_q[c];
      default: dir = right_q[c];
    endcase
    mag = prod_q[47] ? 48'(-prod_q) : 48'(prod_q);
    disp = 34'($signed({1'b0, (mag + 48'd8192) >> 14}));
    if (prod_q[47]) begin
      disp = -disp;
    end
    dsel = (k == 2'd1 || k == 2'd2) ? -disp : disp;
    psum = 34'(pos_q[c]) + dsel;
    rstep = 14'(5 * $signed({1'b0, turn_speed_q}));
    rsum = 19'(roll_q);
    if (keys_q[4] && !keys_q[5]) begin
      rsum = rsum - 19'(rstep);
    end else if (keys_q[5] && !keys_q[4]) begin
      rsum = rsum + 19'(rstep);
    end
    if (rsum > 19'(fcfu_pkg::RollHalf)) begin
      rsum = rsum - 19'(fcfu_pkg::RollFull);
    end else if (rsum < -19'(fcfu_pkg::RollHalf)) begin
      rsum = rsum + 19'(fcfu_pkg::RollFull);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_speed_q <= 16'd5120;
      turn_speed_q <= 10'd102;
      pos_q[0] <= 32'sd0;
      pos_q[1] <= 32'sd1310720;
      pos_q[2] <= 32'sd1310720;
      for (int i = 0; i < 3; i++) begin
        front_q[i] <= '0;
        right_q[i] <= '0;
        up_q[i] <= '0;
      end
      yaw_q <= 9'd270;
      pitch_q <= -8'sd45;
      roll_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fcfu_pkg::RegTurnSpeed) begin
          turn_speed_q <= cfg_data_i[9:0];
        end else begin
          move_speed_q <= cfg_data_i;
        end
      end
      if (cmd_i.angle) begin
        yaw_q <= yaw_rem[8:0];
        pitch_q <= np[7:0];
        roll_q <= rsum[16:0];
      end
      if (cmd_i.vec) begin
        front_q[0] <= fcfu_pkg::mul_q14(cy_t_q, cp_t_q);
        front_q[1] <= sp_t_q;
        front_q[2] <= fcfu_pkg::mul_q14(sy_t_q, cp_t_q);
        right_q[0] <= -sy_t_q;
        right_q[1] <= '0;
        right_q[2] <= cy_t_q;
        up_q[0] <= -fcfu_pkg::mul_q14(cy_t_q, sp_t_q);
        up_q[1] <= cp_t_q;
        up_q[2] <= -fcfu_pkg::mul_q14(sy_t_q, sp_t_q);
      end
      if (cmd_i.move_add) begin
        if (psum > 34'sd2147483647) begin
          pos_q[c] <= 32'sh7fffffff;
        end else if (psum < -34'sd2147483648) begin
          pos_q[c] <= 32'sh80000000;
        end else begin
          pos_q[c] <= psum[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q <= mouse_dx_i;
      dy_q <= mouse_dy_i;
      ft_q <= frame_time_i;
      keys_q <= keys_i;
    end
    if (cmd_i.scale) begin
      sx_q <= qx;
      sy_q <= qy;
    end
    if (cmd_i.trig) begin
      sy_t_q <= fcfu_pkg::sin_deg(yaw_q);
      cy_t_q <= fcfu_pkg::cos_deg(yaw_q);
      sp_t_q <= fcfu_pkg::sin_deg(pitch_q[7] ? 9'(10'sd360 + 10'(pitch_q))
                                               : 9'(pitch_q));
      cp_t_q <= fcfu_pkg::cos_deg(pitch_q[7] ? 9'(10'sd360 + 10'(pitch_q))
                                               : 9'(pitch_q));
    end
    if (cmd_i.vel) begin
      vel_q <= 32'((move_speed_q * ft_q) >> 8);
    end
    if (cmd_i.move_mul) begin
      prod_q <= 48'(dir) * $signed({16'd0, vel_q});
    end
    if (cmd_i.finish) begin
      pos_out_q <= pos_q;
      front_out_q <= front_q;
      up_out_q <= up_q;
      yaw_out_q <= yaw_q;
      pitch_out_q <= pitch_q;
      roll_out_q <= roll_q;
    end
  end

  assign pos_o = pos_out_q;
  assign front_o = front_out_q;
  assign up_o = up_out_q;
  assign yaw_o = yaw_out_q;
  assign pitch_o = pitch_out_q;
  assign roll_o = roll_out_q;
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the fly camera frame update unit.
// Drives random and directed frames, predicts each result in-bench and compares.
// Depends on fcfu_pkg and the fly_camera_frame_update_unit RTL.
`timescale 1ns / 1ps
module testbench;
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] mouse_dx_i = '0;
  logic signed [15:0] mouse_dy_i = '0;
  logic [15:0]        frame_time_i = '0;
  logic               key_forward_i = 1'b0;
  logic               key_back_i = 1'b0;
  logic               key_left_i = 1'b0;
  logic               key_right_i = 1'b0;
  logic               key_roll_minus_i = 1'b0;
  logic               key_roll_plus_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] front_x_o, front_y_o, front_z_o, up_x_o, up_y_o, up_z_o;
  logic [8:0]         yaw_deg_o;
  logic signed [7:0]  pitch_deg_o;
  logic signed [16:0] roll_angle_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;

  localparam int   IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        ft;
    logic [5:0]         keys; // forward, back, left, right, roll minus, roll plus
  } frame_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz, ux, uy, uz;
    logic [8:0]         yaw;
    logic signed [7:0]  pitch;
    logic signed [16:0] roll;
  } pose_t;

  fly_camera_frame_update_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frame_t frame_q[$];
  pose_t  pose_q[$];
  bit     failed = 0;
  bit     idle_on = 1;
  bit     in_taken = 0;
  int     idle_cnt = 0;

  // camera state tracked by the predictor
  int     spd_move = 5120, spd_turn = 102;
  longint cam_pos[3];
  int     cam_yaw = 270, cam_pitch = -45, cam_roll = 0;

  function automatic int sine_of(int d);
    int t[91] = '{0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384};
    int a;
    a = d % 360;
    if (a < 0) a += 360;
    if (a <= 90) return t[a];
    if (a <= 180) return t[180 - a];
    if (a <= 270) return -t[a - 180];
    return -t[360 - a];
  endfunction

  function automatic longint round_q14(longint p);
    longint m;
    m = p < 0 ? -p : p;
    m = (m + 8192) >>> 14;
    return p < 0 ? -m : m;
  endfunction

  function automatic void shift_camera(int dir[3], longint vel, bit neg);
    longint s;
    for (int i = 0; i < 3; i++) begin
      s = cam_pos[i] + (neg ? -round_q14(dir[i] * vel) : round_q14(dir[i] * vel));
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      cam_pos[i] = s;
    end
  endfunction

  function automatic pose_t advance_camera(frame_t f);
    pose_t r;
    int sx, sy, sY, cY, sP, cP, np;
    int fr[3], rt[3];
    longint vel;
    sx = (int'(f.dx) * spd_turn) / 256;
    sy = (int'(f.dy) * spd_turn) / 256;
    cam_yaw = (cam_yaw + sx) % 360;
    if (cam_yaw < 0) cam_yaw += 360;
    np = cam_pitch - sy;
    if (np >= 89) np = 89;
    if (np <= -89) np = -89;
    cam_pitch = np;
    sY = sine_of(cam_yaw);
    cY = sine_of(cam_yaw + 90);
    sP = sine_of(np);
    cP = sine_of(np + 90);
    fr[0] = int'(round_q14(longint'(cY * cP)));
    fr[1] = sP;
    fr[2] = int'(round_q14(longint'(sY * cP)));
    rt[0] = -sY;
    rt[1] = 0;
    rt[2] = cY;
    vel = (longint'(spd_move) * f.ft) >>> 8;
    if (f.keys[5]) shift_camera(fr, vel, 0);
    if (f.keys[4]) shift_camera(fr, vel, 1);
    if (f.keys[3]) shift_camera(rt, vel, 1);
    if (f.keys[2]) shift_camera(rt, vel, 0);
    if (f.keys[1]) cam_roll -= 5 * spd_turn;
    if (f.keys[0]) cam_roll += 5 * spd_turn;
    if (cam_roll > 46080) cam_roll -= 92160;
    else if (cam_roll < -46080) cam_roll += 92160;
    r.px = 32'(cam_pos[0]);
    r.py = 32'(cam_pos[1]);
    r.pz = 32'(cam_pos[2]);
    r.fx = 16'(fr[0]);
    r.fy = 16'(fr[1]);
    r.fz = 16'(fr[2]);
    r.ux = 16'(-round_q14(longint'(cY * sP)));
    r.uy = 16'(cP);
    r.uz = 16'(-round_q14(longint'(sY * sP)));
    r.yaw = 9'(cam_yaw);
    r.pitch = 8'(cam_pitch);
    r.roll = 17'(cam_roll);
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    frame_t f;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (frame_q.size() > 0 && !(idle_on && $urandom_range(99) < 20)) begin
          f = frame_q.pop_front();
          in_valid_i <= 1'b1;
          mouse_dx_i <= f.dx;
          mouse_dy_i <= f.dy;
          frame_time_i <= f.ft;
          {key_forward_i, key_back_i, key_left_i, key_right_i,
           key_roll_minus_i, key_roll_plus_i} <= f.keys;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= idle_on && $urandom_range(99) < 20;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pose_t e, a;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        pose_q.push_back(advance_camera({mouse_dx_i, mouse_dy_i, frame_time_i,
          key_forward_i, key_back_i, key_left_i, key_right_i,
          key_roll_minus_i, key_roll_plus_i}));
      if (out_valid_o && !out_stall_i) begin
        a = {pos_x_o, pos_y_o, pos_z_o, front_x_o, front_y_o, front_z_o,
             up_x_o, up_y_o, up_z_o, yaw_deg_o, pitch_deg_o, roll_angle_o};
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, a);
          failed = 1;
        end else begin
          e = pose_q.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, a);
            $display("  pos %0d %0d %0d / %0d %0d %0d", e.px, e.py, e.pz, a.px, a.py, a.pz);
            $display("  front %0d %0d %0d / %0d %0d %0d", e.fx, e.fy, e.fz, a.fx, a.fy, a.fz);
            $display("  up %0d %0d %0d / %0d %0d %0d", e.ux, e.uy, e.uz, a.ux, a.uy, a.uz);
            $display("  yaw %0d/%0d pitch %0d/%0d roll %0d/%0d", e.yaw, a.yaw,
                     e.pitch, a.pitch, e.roll, a.roll);
            failed = 1;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == fcfu_pkg::RegMoveSpeed) spd_move = int'(val);
    else spd_turn = int'(val[9:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_frames();
    while (frame_q.size() > 0 || pose_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic frame_t rand_frame();
    frame_t f;
    f.dx = 16'($urandom);
    f.dy = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      f.dx = $signed(f.dx) >>> $urandom_range(15, 6);
      f.dy = $signed(f.dy) >>> $urandom_range(15, 6);
    end
    f.ft = 16'($urandom);
    f.keys = 6'($urandom);
    return f;
  endfunction

  initial begin
    cam_pos[0] = 0;
    cam_pos[1] = 20 * 65536;
    cam_pos[2] = 20 * 65536;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: extremes, each key alone, opposite pairs, both roll keys
    frame_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'hFFFF, 6'b100000});
    frame_q.push_back('{-16'sh8000, -16'sh8000, 16'hFFFF, 6'b010000});
    frame_q.push_back('{16'sd0, 16'sd0, 16'd0, 6'b000000});
    frame_q.push_back('{16'sd1, -16'sd1, 16'h1000, 6'b001000});
    frame_q.push_back('{-16'sd1, 16'sd1, 16'h1000, 6'b000100});
    frame_q.push_back('{16'sd300, 16'sd0, 16'h8000, 6'b000010});
    frame_q.push_back('{-16'sd300, 16'sd0, 16'h8000, 6'b000001});
    frame_q.push_back('{16'sd0, 16'sd0, 16'hFFFF, 6'b110000});
    frame_q.push_back('{16'sd0, 16'sd0, 16'hFFFF, 6'b001100});
    frame_q.push_back('{16'sd0, 16'sd0, 16'hFFFF, 6'b000011});
    frame_q.push_back('{16'sd0, 16'sd200, 16'h4000, 6'b111111});
    drain_frames();
    write_reg(fcfu_pkg::RegMoveSpeed, 16'hFFFF);
    write_reg(fcfu_pkg::RegTurnSpeed, 16'h03FF);
    for (int i = 0; i < 12; i++) begin
      frame_q.push_back('{16'sd0, 16'sd0, 16'hFFFF, 6'b100010});
      frame_q.push_back(rand_frame());
    end
    drain_frames();
    // random phases over several settings, incl. zero speeds
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(fcfu_pkg::RegMoveSpeed, 16'd0);
          write_reg(fcfu_pkg::RegTurnSpeed, 16'd0);
        end
        1: begin
          write_reg(fcfu_pkg::RegMoveSpeed, 16'd5120);
          write_reg(fcfu_pkg::RegTurnSpeed, 16'd102);
        end
        5: begin
          write_reg(fcfu_pkg::RegMoveSpeed, 16'hFFFF);
          write_reg(fcfu_pkg::RegTurnSpeed, 16'h3FF);
        end
        default: begin
          write_reg(fcfu_pkg::RegMoveSpeed, 16'($urandom));
          write_reg(fcfu_pkg::RegTurnSpeed, 16'($urandom));
        end
      endcase
      idle_on = (ph != 3);
      for (int i = 0; i < 220; i++) begin
        frame_q.push_back(rand_frame());
        if (ph == 2 && i == 109) begin
          while (frame_q.size() > 0 || pose_q.size() > 0 || in_valid_i) @(posedge clk_i);
        end
      end
      drain_frames();
    end
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/fcfu_pkg.sv
design/fcfu_ctrl.sv
design/fcfu_dp.sv
design/fly_camera_frame_update_unit.sv
sim/testbench.sv
